// ===== hdl/escape_run_length_encoder_assert.svh =====
// Assertion macros shared by the encoder; each expands to one concurrent assertion.
`ifndef ESCAPE_RUN_LENGTH_ENCODER_ASSERT_SVH
`define ESCAPE_RUN_LENGTH_ENCODER_ASSERT_SVH

// Same-cycle implication under the asynchronous reset.
`define ERLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under the asynchronous reset.
`define ERLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/erle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package erle_pkg;

	// Run-length stream: 7-bit groups, top bit flags that another group follows.
	localparam int GROUP_BITS = 7;
	localparam logic [7:0] CONT_FLAG = 8'h80;

	// Escape byte after reset.
	localparam logic [7:0] ESC_RESET = 8'hFF;

	// Steps of one run close: the groups (five for a 32-bit count), the escape and the byte.
	localparam int STEP_W = 4;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W = 2;
	localparam int LEVEL_W = 3;

	// Stream select codes.
	localparam logic SEL_SYMBOL = 1'b0;
	localparam logic SEL_RUN = 1'b1;

	// Part of a run-close command that does not depend on the counter width.
	typedef struct packed {
		logic [7:0] run_byte;
		logic       last;
	} erle_tag_t;

	// What the front hands to the queue in one cycle: zero, one or two commands.
	typedef struct packed {
		logic [1:0] n;
		erle_tag_t  a;
		erle_tag_t  b;
	} erle_push_t;

endpackage

`default_nettype wire

// ===== hdl/erle_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module erle_queue #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire erle_pkg::erle_push_t   push,
	input  wire logic [COUNT_BITS-1:0]  len_a,
	input  wire logic [COUNT_BITS-1:0]  len_b,
	output logic                        room,
	output logic                        head_valid,
	output erle_pkg::erle_tag_t         head_tag,
	output logic [COUNT_BITS-1:0]       head_len,
	input  wire logic                   pop
);

	localparam int PW = erle_pkg::PTR_W;
	localparam int LW = erle_pkg::LEVEL_W;

	erle_pkg::erle_tag_t   tag_q [erle_pkg::QUEUE_DEPTH];
	logic [COUNT_BITS-1:0] len_q [erle_pkg::QUEUE_DEPTH];
	logic [PW-1:0]         wptr_q;
	logic [PW-1:0]         rptr_q;
	logic [LW-1:0]         level_q;

	// Room for two commands, so a full item can always be taken.
	assign room       = level_q <= LW'(erle_pkg::QUEUE_DEPTH - 2);
	assign head_valid = level_q != '0;
	assign head_tag   = tag_q[rptr_q];
	assign head_len   = len_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			tag_q[wptr_q] <= push.a;
			len_q[wptr_q] <= len_a;
		end
		if (push.n == 2'd2) begin
			tag_q[wptr_q + PW'(1)] <= push.b;
			len_q[wptr_q + PW'(1)] <= len_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PW'(push.n);
			rptr_q  <= rptr_q + PW'(pop);
			level_q <= level_q + LW'(push.n) - LW'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/erle_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module erle_front #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   end_of_block,
	output erle_pkg::erle_push_t        push,
	output logic [COUNT_BITS-1:0]       len_a,
	output logic [COUNT_BITS-1:0]       len_b
);

	logic [7:0]            run_byte_q;
	logic [COUNT_BITS-1:0] run_len_q;
	logic                  extend;
	logic                  close_prev;
	logic [COUNT_BITS-1:0] new_len;
	erle_pkg::erle_tag_t   prev_tag;
	erle_pkg::erle_tag_t   cur_tag;

	// The open run grows unless the byte differs or the counter is full.
	assign extend     = (run_len_q != '0) && (data_byte == run_byte_q) && (run_len_q != '1);
	assign close_prev = (run_len_q != '0) && !extend;
	assign new_len    = extend ? run_len_q + COUNT_BITS'(1) : COUNT_BITS'(1);

	always_comb begin
		prev_tag.run_byte = run_byte_q;
		prev_tag.last     = !end_of_block;
		cur_tag.run_byte  = data_byte;
		cur_tag.last      = 1'b1;
		push.a = prev_tag;
		push.b = cur_tag;
		len_a  = run_len_q;
		len_b  = new_len;
		push.n = 2'd0;
		if (accept) begin
			priority if (close_prev && end_of_block) begin
				push.n = 2'd2;
			end else if (close_prev) begin
				push.n = 2'd1;
			end else if (end_of_block) begin
				push.n = 2'd1;
				push.a = cur_tag;
				len_a  = new_len;
			end else begin
				push.n = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_byte_q <= '0;
			run_len_q  <= '0;
		end else if (accept) begin
			run_byte_q <= data_byte;
			run_len_q  <= end_of_block ? '0 : new_len;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/erle_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module erle_back #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [7:0]             escape_byte,
	input  wire logic                   head_valid,
	input  wire erle_pkg::erle_tag_t    head_tag,
	input  wire logic [COUNT_BITS-1:0]  head_len,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        stream_select,
	output logic [7:0]                  out_byte,
	output logic                        out_last
);

	localparam int GB     = erle_pkg::GROUP_BITS;
	localparam int SW     = erle_pkg::STEP_W;
	localparam int GROUPS = (COUNT_BITS + GB - 1) / GB;
	localparam int PAD_W  = GROUPS * GB;

	logic [SW-1:0]    step_q;
	logic             out_valid_q;
	logic             sel_q;
	logic [7:0]       byte_q;
	logic             last_q;

	logic [PAD_W-1:0] len_pad;
	logic [SW-1:0]    num_groups;
	logic [SW-1:0]    group_idx;
	logic [SW-1:0]    total;
	logic [GB-1:0]    grp;
	logic             is_esc;
	logic             encoded;
	logic             add_byte;
	logic             final_step;
	logic             fire;
	logic             sel_d;
	logic [7:0]       byte_d;

	always_comb begin
		len_pad    = PAD_W'(head_len);
		num_groups = SW'(1);
		for (int g = 1; g < GROUPS; g++) begin
			if ((len_pad >> (GB * g)) != '0) begin
				num_groups = SW'(g + 1);
			end
		end
		is_esc   = head_tag.run_byte == escape_byte;
		encoded  = is_esc || (head_len >= COUNT_BITS'(3));
		add_byte = !is_esc || (head_len > COUNT_BITS'(1));
		if (encoded) begin
			total = num_groups + SW'(1) + SW'(add_byte);
		end else begin
			total = (head_len == COUNT_BITS'(2)) ? SW'(2) : SW'(1);
		end
		group_idx = num_groups - SW'(1) - step_q;
		grp = '0;
		for (int g = 0; g < GROUPS; g++) begin
			if (group_idx == SW'(g)) begin
				grp = len_pad[GB * g +: GB];
			end
		end
		priority if (encoded && (step_q < num_groups)) begin
			sel_d  = erle_pkg::SEL_RUN;
			byte_d = 8'(grp) | ((group_idx != '0) ? erle_pkg::CONT_FLAG : 8'h00);
		end else if (encoded && (step_q == num_groups)) begin
			sel_d  = erle_pkg::SEL_SYMBOL;
			byte_d = escape_byte;
		end else begin
			sel_d  = erle_pkg::SEL_SYMBOL;
			byte_d = head_tag.run_byte;
		end
		final_step = step_q == total - SW'(1);
	end

	assign fire = head_valid && (!out_valid_q || out_ready);
	assign pop  = fire && final_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				step_q <= final_step ? '0 : step_q + SW'(1);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sel_q  <= sel_d;
			byte_q <= byte_d;
			last_q <= final_step && head_tag.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign stream_select = sel_q;
	assign out_byte      = byte_q;
	assign out_last      = last_q;

endmodule

`default_nettype wire

// ===== hdl/escape_run_length_encoder.sv =====
// An accepted item's run-close commands are written into the command queue; the back end
// registers each result byte and sends one result byte per cycle while out_ready is high;
// the front goes on taking items while the back end is still expanding earlier commands.
// A four-entry command queue parts the front from the back, so either side stalls alone.
// Reset (arst_n low, asynchronous) empties the queue, drops any open run, sets escape to 255.
`timescale 1ns / 1ps
`default_nettype none

`include "escape_run_length_encoder_assert.svh"

module escape_run_length_encoder #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Configuration: the escape byte.
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	// Input items.
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_block,
	// Result items.
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            stream_select,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	// The escape byte is read by the back end when it expands a run. The user
	// must make writes arrive only while the block is idle; the block does not
	// enforce this, and a queued run sees the value current when it is expanded.
	logic [7:0] escape_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= erle_pkg::ESC_RESET;
		end else if (cfg_we) begin
			escape_q <= cfg_wdata;
		end
	end

	erle_pkg::erle_push_t  push;
	logic [COUNT_BITS-1:0] len_a;
	logic [COUNT_BITS-1:0] len_b;
	logic                  room;
	logic                  head_valid;
	erle_pkg::erle_tag_t   head_tag;
	logic [COUNT_BITS-1:0] head_len;
	logic                  pop;
	logic                  accept;

	// An item can close at most two runs: the one it breaks and, at the end
	// of a block, the one it belongs to. The front is ready whenever the
	// queue has room for both.
	assign in_ready = room;
	assign accept   = in_valid && room;

	// The front keeps the open run and turns each item into run-close commands.
	erle_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.end_of_block (end_of_block),
		.push         (push),
		.len_a        (len_a),
		.len_b        (len_b)
	);

	erle_queue #(
		.COUNT_BITS (COUNT_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.len_a      (len_a),
		.len_b      (len_b),
		.room       (room),
		.head_valid (head_valid),
		.head_tag   (head_tag),
		.head_len   (head_len),
		.pop        (pop)
	);

	// The back expands the command at the head of the queue, one byte per
	// cycle while out_ready allows: run-length groups, most significant first,
	// then the escape and the byte (none for a lone escape), or one or two literals for a short run.
	erle_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.escape_byte   (escape_q),
		.head_valid    (head_valid),
		.head_tag      (head_tag),
		.head_len      (head_len),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.stream_select (stream_select),
		.out_byte      (out_byte),
		.out_last      (out_last)
	);

	// With nothing queued the front must be able to take an item.
	`ERLE_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !head_valid, in_ready, "queue empty but not ready")
	// A command leaves the queue only while one is there.
	`ERLE_ASSERT_NOW(a_pop_has_head, clk, arst_n, pop, head_valid, "pop from an empty queue")
	// A new result appears only after the back end had a command to expand.
	`ERLE_ASSERT_NEXT(a_result_from_head, clk, arst_n, !out_valid && !head_valid, !out_valid, "result without a command")

endmodule

`default_nettype wire
